>>> rtl/ax25_ui_frame_kiss_encoder_top_defines.svh
// assertion macros shared by the encoder rtl
// expects clk_i and rst_ni in the module that uses them
`ifndef AX25_UI_FRAME_KISS_ENCODER_TOP_DEFINES_SVH
`define AX25_UI_FRAME_KISS_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define AX25K_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AX25K_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ax25kiss_pkg.sv
// types, constants and header byte table for the kiss / ax.25 ui encoder
// no dependencies
package ax25kiss_pkg;

  localparam logic [7:0] KissFend    = 8'hC0;
  localparam logic [7:0] KissFesc    = 8'hDB;
  localparam logic [7:0] KissTfend   = 8'hDC;
  localparam logic [7:0] KissTfesc   = 8'hDD;
  localparam logic [7:0] KissCmdData = 8'h00;
  localparam logic [7:0] Ax25CtrlUi  = 8'h03;
  localparam logic [7:0] Ax25PidNone = 8'hF0;
  localparam logic [7:0] AsciiSpace  = 8'h20;

  localparam int unsigned HdrIdxW = 5;
  // header burst: fend, cmd, 7 dest bytes, 7 src bytes, ctrl, pid
  localparam logic [HdrIdxW-1:0] HdrFend     = 5'd0;
  localparam logic [HdrIdxW-1:0] HdrCmd      = 5'd1;
  localparam logic [HdrIdxW-1:0] HdrDestCall = 5'd2;
  localparam logic [HdrIdxW-1:0] HdrDestSsid = 5'd8;
  localparam logic [HdrIdxW-1:0] HdrSrcCall  = 5'd9;
  localparam logic [HdrIdxW-1:0] HdrSrcSsid  = 5'd15;
  localparam logic [HdrIdxW-1:0] HdrCtrl     = 5'd16;
  localparam logic [HdrIdxW-1:0] HdrPid      = 5'd17;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 48;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEST_CALL = 2'd0,
    CFG_DEST_SSID = 2'd1,
    CFG_SRC_CALL  = 2'd2,
    CFG_SRC_SSID  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [47:0] dest_callsign;
    logic [3:0]  dest_ssid;
    logic [47:0] src_callsign;
    logic [3:0]  src_ssid;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  // one queued job: the payload byte, its last-byte flag and whether a header goes first
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       hdr;
  } job_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_HDR  = 2'd1,
    BK_PAY  = 2'd2,
    BK_FEND = 2'd3
  } back_state_e;

  // callsign character k (0 = top byte), zero sent as space, shifted left
  function automatic logic [7:0] addr_char(logic [47:0] call, logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = call[47:40];
      3'd1:    c = call[39:32];
      3'd2:    c = call[31:24];
      3'd3:    c = call[23:16];
      3'd4:    c = call[15:8];
      default: c = call[7:0];
    endcase
    if (c == 8'h00) begin
      c = AsciiSpace;
    end
    return {c[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] hdr_byte(logic [HdrIdxW-1:0] idx, cfg_t cfg);
    logic [7:0] b;
    logic [HdrIdxW-1:0] off;
    b = KissFend;
    off = '0;
    if (idx == HdrFend) begin
      b = KissFend;
    end else if (idx == HdrCmd) begin
      b = KissCmdData;
    end else if (idx < HdrDestSsid) begin
      off = idx - HdrDestCall;
      b = addr_char(cfg.dest_callsign, off[2:0]);
    end else if (idx == HdrDestSsid) begin
      b = {3'b011, cfg.dest_ssid, 1'b0};
    end else if (idx < HdrSrcSsid) begin
      off = idx - HdrSrcCall;
      b = addr_char(cfg.src_callsign, off[2:0]);
    end else if (idx == HdrSrcSsid) begin
      b = {3'b011, cfg.src_ssid, 1'b1};
    end else if (idx == HdrCtrl) begin
      b = Ax25CtrlUi;
    end else begin
      b = Ax25PidNone;
    end
    return b;
  endfunction

endpackage

>>> rtl/ax25_ui_frame_kiss_encoder_top.sv
// path: a taken byte goes into the job queue, then the back's job register, then the output register
// throughput: one output byte per cycle while not stalled; each payload job is first fetched in idle
// an escaped byte is sent as fesc and its transposed code; a last byte is followed by the fend
// a frame start adds the 18-byte header burst (more with escapes), set by the back sequencer
// reset: asynchronous active low, clears control state and the callsign and ssid registers
// depends on ax25kiss_pkg, ax25kiss_front, ax25kiss_fifo, ax25kiss_back
module ax25_ui_frame_kiss_encoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ax25kiss_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ax25kiss_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ax25kiss_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ax25kiss_pkg::out_item_t             out_data_o
);

  ax25kiss_pkg::cfg_t cfg_q, cfg_d;
  logic push, q_ready, pop, job_valid;
  ax25kiss_pkg::job_t push_job, head_job;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ax25kiss_pkg::cfg_idx_e'(cfg_idx_i))
        ax25kiss_pkg::CFG_DEST_CALL: cfg_d.dest_callsign = cfg_wdata_i[47:0];
        ax25kiss_pkg::CFG_DEST_SSID: cfg_d.dest_ssid     = cfg_wdata_i[3:0];
        ax25kiss_pkg::CFG_SRC_CALL:  cfg_d.src_callsign  = cfg_wdata_i[47:0];
        ax25kiss_pkg::CFG_SRC_SSID:  cfg_d.src_ssid      = cfg_wdata_i[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ax25kiss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (push_job),
    .q_ready_i  (q_ready)
  );

  ax25kiss_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (head_job)
  );

  ax25kiss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/ax25kiss_front.sv
// front end: takes payload byte transfers and tags frame starts
// depends on ax25kiss_pkg
module ax25kiss_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ax25kiss_pkg::in_item_t in_data_i,
  output logic                   push_o,
  output ax25kiss_pkg::job_t     job_o,
  input  logic                   q_ready_i
);

  logic frame_open_q, frame_open_d;

  assign in_stall_o = !q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    job_o.payload_byte = in_data_i.payload_byte;
    job_o.last_byte    = in_data_i.last_byte;
    job_o.hdr          = !frame_open_q;
    frame_open_d       = frame_open_q;
    if (push_o) begin
      frame_open_d = !in_data_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

>>> rtl/ax25kiss_fifo.sv
// two-entry job queue between front and back
// depends on ax25kiss_pkg and the assertion macro header
`include "ax25_ui_frame_kiss_encoder_top_defines.svh"
module ax25kiss_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ax25kiss_pkg::job_t push_data_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ax25kiss_pkg::job_t pop_data_o
);

  ax25kiss_pkg::job_t mem_q [ax25kiss_pkg::QDepth];
  logic [ax25kiss_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ax25kiss_pkg::QCntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign ready_o    = (count_q != ax25kiss_pkg::QCntW'(ax25kiss_pkg::QDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `AX25K_ASSERT_IMP(a_cnt_bound, 1'b1, count_q <= ax25kiss_pkg::QCntW'(ax25kiss_pkg::QDepth), "queue count over depth")
  `AX25K_ASSERT_IMP(a_pop_nonempty, pop_i, count_q != '0, "pop from empty queue")
  `AX25K_ASSERT_NXT(a_cnt_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "count not bumped on push")

endmodule

>>> rtl/ax25kiss_back.sv
// back end: sequences header, escaped payload and closing fend into the output register
// depends on ax25kiss_pkg and the assertion macro header
`include "ax25_ui_frame_kiss_encoder_top_defines.svh"
module ax25kiss_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ax25kiss_pkg::cfg_t      cfg_i,
  input  logic                    job_valid_i,
  input  ax25kiss_pkg::job_t      job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output ax25kiss_pkg::out_item_t out_data_o
);

  ax25kiss_pkg::back_state_e state_q, state_d;
  logic [ax25kiss_pkg::HdrIdxW-1:0] hdr_idx_q, hdr_idx_d;
  ax25kiss_pkg::job_t cur_q, cur_d;
  logic esc_pend_q, esc_pend_d;
  logic [7:0] esc2_q, esc2_d;
  ax25kiss_pkg::out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic load_ok, esc_ok, need_esc, adv;
  logic [7:0] raw, emit;

  assign load_ok     = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    // byte under work and its escaping
    if (state_q == ax25kiss_pkg::BK_HDR) begin
      raw    = ax25kiss_pkg::hdr_byte(hdr_idx_q, cfg_i);
      esc_ok = (hdr_idx_q > ax25kiss_pkg::HdrCmd);
    end else begin
      raw    = cur_q.payload_byte;
      esc_ok = 1'b1;
    end
    need_esc = esc_ok && (raw == ax25kiss_pkg::KissFend || raw == ax25kiss_pkg::KissFesc);

    esc_pend_d = esc_pend_q;
    esc2_d     = esc2_q;
    if (esc_pend_q) begin
      emit = esc2_q;
      adv  = 1'b1;
    end else if (need_esc) begin
      emit = ax25kiss_pkg::KissFesc;
      adv  = 1'b0;
    end else begin
      emit = raw;
      adv  = 1'b1;
    end

    state_d     = state_q;
    hdr_idx_d   = hdr_idx_q;
    cur_d       = cur_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;

    case (state_q)
      ax25kiss_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          pop_o     = 1'b1;
          cur_d     = job_i;
          hdr_idx_d = '0;
          state_d   = job_i.hdr ? ax25kiss_pkg::BK_HDR : ax25kiss_pkg::BK_PAY;
        end
      end
      ax25kiss_pkg::BK_HDR, ax25kiss_pkg::BK_PAY: begin
        if (load_ok) begin
          out_valid_d     = 1'b1;
          out_d.out_byte  = emit;
          out_d.frame_end = 1'b0;
          out_d.run_last  = (state_q == ax25kiss_pkg::BK_PAY) && adv && !cur_q.last_byte;
          if (!esc_pend_q && need_esc) begin
            esc_pend_d = 1'b1;
            esc2_d = (raw == ax25kiss_pkg::KissFend) ? ax25kiss_pkg::KissTfend
                                                     : ax25kiss_pkg::KissTfesc;
          end
          if (adv) begin
            esc_pend_d = 1'b0;
            if (state_q == ax25kiss_pkg::BK_HDR) begin
              if (hdr_idx_q == ax25kiss_pkg::HdrPid) begin
                state_d = ax25kiss_pkg::BK_PAY;
              end else begin
                hdr_idx_d = hdr_idx_q + 1'b1;
              end
            end else begin
              state_d = cur_q.last_byte ? ax25kiss_pkg::BK_FEND : ax25kiss_pkg::BK_IDLE;
            end
          end
        end
      end
      ax25kiss_pkg::BK_FEND: begin
        if (load_ok) begin
          out_valid_d     = 1'b1;
          out_d.out_byte  = ax25kiss_pkg::KissFend;
          out_d.frame_end = 1'b1;
          out_d.run_last  = 1'b1;
          state_d         = ax25kiss_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = ax25kiss_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    esc2_q <= esc2_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ax25kiss_pkg::BK_IDLE;
      hdr_idx_q   <= '0;
      esc_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_idx_q   <= hdr_idx_d;
      esc_pend_q  <= esc_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  `AX25K_ASSERT_IMP(a_end_is_fend, out_valid_q && out_q.frame_end, out_q.out_byte == ax25kiss_pkg::KissFend && out_q.run_last, "frame end not on a closing fend")
  `AX25K_ASSERT_IMP(a_esc_follows, esc_pend_q, out_valid_q && out_q.out_byte == ax25kiss_pkg::KissFesc, "escape pending without fesc shown")
  `AX25K_ASSERT_IMP(a_idle_clean, state_q == ax25kiss_pkg::BK_IDLE, !esc_pend_q, "idle with escape pending")

endmodule
